// ===== design/tile_run_header_generator_unit_assert.svh =====
// Assertion macros used by the tile walker of the tile run header generator RTL.
`ifndef TILE_RUN_HEADER_GENERATOR_UNIT_ASSERT_SVH
`define TILE_RUN_HEADER_GENERATOR_UNIT_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define TRHG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property that must hold in the cycle after the trigger.
`define TRHG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/trhg_pkg.sv =====
// Shared types and constants of the tile run header generator.
package trhg_pkg;

    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;
    localparam int SEQ_W           = 14;
    localparam int POSE_HDR_LEN    = 26;
    localparam int DIR_ENTRY_BYTES = 4;

    typedef enum logic [1:0] {
        REG_RUN_LIMIT   = 2'd0,
        REG_TILE_SIZE   = 2'd1,
        REG_TWO_PATHS   = 2'd2,
        REG_POSE_ENABLE = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLASS_LOW  = 2'd0,
        CLASS_MID  = 2'd1,
        CLASS_HIGH = 2'd2
    } t_run_class;

    typedef struct packed {
        logic [6:0]  run_limit;
        logic [11:0] tile_size;
        logic        two_paths;
        logic        pose_enable;
    } t_cfg;

    typedef struct packed {
        logic [15:0] frame_number;
        logic [11:0] first_tile;
        logic [6:0]  tile_count;
        logic        last_of_frame;
        logic [2:0]  band_index;
        t_run_class  run_class;
        logic        pose_flag;
    } t_run;

    typedef struct packed {
        logic             path_id;
        logic [SEQ_W-1:0] path_sequence;
        logic [31:0]      self_test_sequence;
    } t_path;

endpackage

// ===== design/trhg_cfg_regs.sv =====
// APB configuration registers with readback.
module trhg_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trhg_pkg::ADDR_W-1:0]   paddr,
    input  logic [trhg_pkg::DATA_W-1:0]   pwdata,
    output logic [trhg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output trhg_pkg::t_cfg                o_cfg
);

    trhg_pkg::t_cfg   r_cfg;
    trhg_pkg::t_cfg   n_cfg;
    trhg_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign reg_idx = trhg_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                trhg_pkg::REG_RUN_LIMIT:   n_cfg.run_limit   = pwdata[6:0];
                trhg_pkg::REG_TILE_SIZE:   n_cfg.tile_size   = pwdata[11:0];
                trhg_pkg::REG_TWO_PATHS:   n_cfg.two_paths   = pwdata[0];
                trhg_pkg::REG_POSE_ENABLE: n_cfg.pose_enable = pwdata[0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            trhg_pkg::REG_RUN_LIMIT:   prdata = {25'd0, r_cfg.run_limit};
            trhg_pkg::REG_TILE_SIZE:   prdata = {20'd0, r_cfg.tile_size};
            trhg_pkg::REG_TWO_PATHS:   prdata = {31'd0, r_cfg.two_paths};
            trhg_pkg::REG_POSE_ENABLE: prdata = {31'd0, r_cfg.pose_enable};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_limit   <= 7'd1;
            r_cfg.tile_size   <= 12'd1;
            r_cfg.two_paths   <= 1'b0;
            r_cfg.pose_enable <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/trhg_tile_walker.sv =====
// Tile cursor, row/column/band tracking and per-run header fields.
`include "tile_run_header_generator_unit_assert.svh"

module trhg_tile_walker #(
    parameter int GRID_COLUMNS  = 68,
    parameter int GRID_ROWS     = 34,
    parameter int ROWS_PER_BAND = 6,
    parameter int BAND_COUNT    = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  trhg_pkg::t_cfg i_cfg,
    output trhg_pkg::t_run o_run
);

    localparam int TILE_TOTAL = GRID_COLUMNS * GRID_ROWS;
    localparam int CUR_W      = $clog2(TILE_TOTAL + 1);
    localparam int CUR_XW     = (CUR_W > 12) ? CUR_W : 12;
    localparam int COL_W      = $clog2(GRID_COLUMNS + 1);
    localparam int ROW_W      = $clog2(GRID_ROWS + 1);
    localparam int SUB_W      = $clog2(ROWS_PER_BAND + 1);
    localparam int CMP_W      = (COL_W > 7) ? COL_W : 7;

    logic [CUR_XW-1:0] r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col,    n_col;
    logic [ROW_W-1:0]  r_row,    n_row;
    logic [SUB_W-1:0]  r_sub,    n_sub;     // row within band
    logic [2:0]        r_band,   n_band;    // saturates at last band
    logic [15:0]       r_frame,  n_frame;

    logic [6:0]        per_run;
    logic [COL_W-1:0]  remaining;
    logic [CMP_W-1:0]  cnt_a, cnt_b, cnt_min;
    logic [6:0]        count;
    logic [COL_W:0]    col_sum;
    logic              row_end;
    logic              frame_end;
    logic              band_wrap;
    trhg_pkg::t_run_class run_class;

    assign per_run   = (i_cfg.run_limit == 7'd0) ? 7'd1 : i_cfg.run_limit;
    assign remaining = COL_W'(GRID_COLUMNS) - r_col;
    assign cnt_a     = CMP_W'(per_run);
    assign cnt_b     = CMP_W'(remaining);
    assign cnt_min   = (cnt_a < cnt_b) ? cnt_a : cnt_b;
    assign count     = cnt_min[6:0];

    assign col_sum   = {1'b0, r_col} + (COL_W + 1)'(count);
    assign row_end   = (col_sum == (COL_W + 1)'(GRID_COLUMNS));
    assign frame_end = row_end && (r_row == ROW_W'(GRID_ROWS - 1));
    assign band_wrap = (r_sub == SUB_W'(ROWS_PER_BAND - 1));

    always_comb begin
        case (r_band) inside
            [3'd0:3'd1]: run_class = trhg_pkg::CLASS_LOW;
            [3'd2:3'd3]: run_class = trhg_pkg::CLASS_MID;
            default:     run_class = trhg_pkg::CLASS_HIGH;
        endcase
    end

    always_comb begin
        o_run.frame_number  = r_frame;
        o_run.first_tile    = r_cursor[11:0];
        o_run.tile_count    = count;
        o_run.last_of_frame = frame_end;
        o_run.band_index    = r_band;
        o_run.run_class     = run_class;
        o_run.pose_flag     = i_cfg.pose_enable && (r_col == '0) && (r_sub == '0);
    end

    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        n_row    = r_row;
        n_sub    = r_sub;
        n_band   = r_band;
        n_frame  = r_frame;
        if (i_step) begin
            if (frame_end) begin
                n_cursor = '0;
                n_col    = '0;
                n_row    = '0;
                n_sub    = '0;
                n_band   = '0;
                n_frame  = r_frame + 16'd1;
            end else begin
                n_cursor = r_cursor + CUR_XW'(count);
                if (row_end) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                    if (band_wrap) begin
                        n_sub = '0;
                        if (r_band != 3'(BAND_COUNT - 1)) begin
                            n_band = r_band + 3'd1;
                        end
                    end else begin
                        n_sub = r_sub + SUB_W'(1);
                    end
                end else begin
                    n_col = col_sum[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_sub    <= '0;
            r_band   <= '0;
            r_frame  <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_row    <= n_row;
            r_sub    <= n_sub;
            r_band   <= n_band;
            r_frame  <= n_frame;
        end
    end

    `TRHG_ASSERT(a_run_in_row,
        (col_sum <= (COL_W + 1)'(GRID_COLUMNS)) && (count != 7'd0),
        "run crosses row end or is empty")
    `TRHG_ASSERT_NEXT(a_frame_wrap, i_step && frame_end,
        (r_cursor == '0) && (r_col == '0) && (r_row == '0)
            && (r_frame == $past(r_frame) + 16'd1),
        "frame end did not restart cursor")
    `TRHG_ASSERT_NEXT(a_cursor_adv, i_step && !frame_end,
        (r_frame == $past(r_frame))
            && (r_cursor == $past(r_cursor) + CUR_XW'($past(count))),
        "cursor did not advance by run length")

endmodule

// ===== design/trhg_path_seq.sv =====
// Path selection, per-path sequence numbers and the datagram counter.
module trhg_path_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  trhg_pkg::t_cfg  i_cfg,
    output trhg_pkg::t_path o_path
);

    logic [trhg_pkg::SEQ_W-1:0] r_seq0, n_seq0;
    logic [trhg_pkg::SEQ_W-1:0] r_seq1, n_seq1;
    logic                       r_toggle, n_toggle;
    logic [31:0]                r_dgram, n_dgram;
    logic                       pid;
    logic [trhg_pkg::SEQ_W-1:0] seq;

    assign pid = i_cfg.two_paths && r_toggle;
    assign seq = pid ? r_seq1 : r_seq0;

    assign o_path.path_id            = pid;
    assign o_path.path_sequence      = seq;
    assign o_path.self_test_sequence = r_dgram;

    always_comb begin
        n_seq0   = r_seq0;
        n_seq1   = r_seq1;
        n_toggle = r_toggle;
        n_dgram  = r_dgram;
        if (i_step) begin
            if (pid) begin
                n_seq1 = seq + trhg_pkg::SEQ_W'(1);
            end else begin
                n_seq0 = seq + trhg_pkg::SEQ_W'(1);
            end
            if (i_cfg.two_paths) begin
                n_toggle = !r_toggle;
            end
            n_dgram = r_dgram + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq0   <= '0;
            r_seq1   <= '0;
            r_toggle <= 1'b0;
            r_dgram  <= '0;
        end else begin
            r_seq0   <= n_seq0;
            r_seq1   <= n_seq1;
            r_toggle <= n_toggle;
            r_dgram  <= n_dgram;
        end
    end

endmodule

// ===== design/tile_run_header_generator_unit.sv =====
// Top level of the tile run header generator: handshake, pipeline and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  request | in        | i_valid / o_ready    | i_tx_time
//  header  | out       | o_valid / i_ready    | o_frame_number .. o_stamp_time
//  config  | in        | psel/penable/pwrite  | paddr, pwdata, prdata (pready = 1)
//
// One request per cycle sustained while i_ready stays high; a request passes through
// the input register, then the header register. The walker state and path counters
// advance when a request moves from the input register into the header register.
// Reset (i_rst_n low, synchronous) clears the cursor, frame, path and datagram
// counters and loads the register defaults.
// A stall on i_ready holds the header; o_ready drops only when both registers
// are full and the header is not taken.
module tile_run_header_generator_unit #(
    parameter int GRID_COLUMNS  = 68,
    parameter int GRID_ROWS     = 34,
    parameter int ROWS_PER_BAND = 6,
    parameter int BAND_COUNT    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [31:0]                 i_tx_time,
    // header channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [15:0]                 o_frame_number,
    output logic [11:0]                 o_first_tile,
    output logic [6:0]                  o_tile_count,
    output logic                        o_last_of_frame,
    output logic [2:0]                  o_band_index,
    output logic [1:0]                  o_run_class,
    output logic                        o_pose_flag,
    output logic                        o_path_id,
    output logic [13:0]                 o_path_sequence,
    output logic [15:0]                 o_payload_length,
    output logic [31:0]                 o_self_test_sequence,
    output logic [31:0]                 o_stamp_time,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trhg_pkg::ADDR_W-1:0] paddr,
    input  logic [trhg_pkg::DATA_W-1:0] pwdata,
    output logic [trhg_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    trhg_pkg::t_cfg  cfg;
    trhg_pkg::t_run  run;
    trhg_pkg::t_path path;

    // input register
    logic        r_in_valid, n_in_valid;
    logic [31:0] r_in_time;

    // header register
    logic            r_out_valid, n_out_valid;
    trhg_pkg::t_run  r_run;
    trhg_pkg::t_path r_path;
    logic [15:0]     r_payload;
    logic [31:0]     r_stamp;

    logic        in_take;
    logic        step;      // request moves into the header register
    logic [11:0] tbytes;
    logic [12:0] per_tile;
    logic [19:0] prod;
    logic [15:0] payload;

    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;
    assign in_take = i_valid && o_ready;

    trhg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    trhg_tile_walker #(
        .GRID_COLUMNS  (GRID_COLUMNS),
        .GRID_ROWS     (GRID_ROWS),
        .ROWS_PER_BAND (ROWS_PER_BAND),
        .BAND_COUNT    (BAND_COUNT)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .o_run   (run)
    );

    trhg_path_seq u_path (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .o_path  (path)
    );

    // payload = pose + count * (directory entry + tile bytes), kept to 16 bits
    assign tbytes   = (cfg.tile_size == 12'd0) ? 12'd1 : cfg.tile_size;
    assign per_tile = {1'b0, tbytes} + 13'(trhg_pkg::DIR_ENTRY_BYTES);
    assign prod     = 20'(run.tile_count) * 20'(per_tile);
    assign payload  = 16'(prod + (run.pose_flag ? 20'(trhg_pkg::POSE_HDR_LEN) : 20'd0));

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_time <= i_tx_time;
        end
        if (step) begin
            r_run     <= run;
            r_path    <= path;
            r_payload <= payload;
            r_stamp   <= r_in_time;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_frame_number       = r_run.frame_number;
    assign o_first_tile         = r_run.first_tile;
    assign o_tile_count         = r_run.tile_count;
    assign o_last_of_frame      = r_run.last_of_frame;
    assign o_band_index         = r_run.band_index;
    assign o_run_class          = r_run.run_class;
    assign o_pose_flag          = r_run.pose_flag;
    assign o_path_id            = r_path.path_id;
    assign o_path_sequence      = r_path.path_sequence;
    assign o_payload_length     = r_payload;
    assign o_self_test_sequence = r_path.self_test_sequence;
    assign o_stamp_time         = r_stamp;

endmodule

// ===== sim/tile_run_header_generator_unit_tb.sv =====
// Self-checking testbench for the tile run header generator: directed table, random phases.
module tile_run_header_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Grid geometry, passed to the block so both sides agree.
    localparam int COLS          = 68;
    localparam int ROWS          = 34;
    localparam int ROWS_PER_BAND = 6;
    localparam int BANDS         = 6;
    localparam int TILE_TOTAL    = COLS * ROWS;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 6;    // two-stage pipeline plus margin
    localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000; // cycles with no handshake at all
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_ITEMS    = 125;
    localparam int PRESSURE_PHASE = 4;

    // Expected header: run fields and path fields from the package, plus length and stamp.
    typedef struct packed {
        trhg_pkg::t_run  run;
        trhg_pkg::t_path path;
        logic [15:0]     payload_length;
        logic [31:0]     stamp_time;
    } t_hdr;

    // One line of the directed table: a register write or a request.
    // Requests flagged typed carry hand-computed run fields that override the predictor.
    typedef struct packed {
        bit                 is_write;
        trhg_pkg::t_reg_idx reg_sel;
        logic [31:0]        value;      // register data, or tx_time for a request
        bit                 typed;
        logic [11:0]        first_tile;
        logic [6:0]         tile_count;
        logic               pose_flag;
        logic [15:0]        payload_length;
    } t_dir_row;

    localparam int DIR_ROWS = 28;
    localparam t_dir_row PLAIN_REQUEST = '0;

    // DUT-facing signals; the inputs are known from time zero.
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_tx_time = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_frame_number;
    logic [11:0] o_first_tile;
    logic [6:0]  o_tile_count;
    logic        o_last_of_frame;
    logic [2:0]  o_band_index;
    logic [1:0]  o_run_class;
    logic        o_pose_flag;
    logic        o_path_id;
    logic [13:0] o_path_sequence;
    logic [15:0] o_payload_length;
    logic [31:0] o_self_test_sequence;
    logic [31:0] o_stamp_time;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [trhg_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [trhg_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [trhg_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // Predictor state: register copy and walker / path / datagram counters.
    trhg_pkg::t_cfg cfg_q;
    int unsigned    cursor_q;
    logic [15:0]    frame_q;
    logic [13:0]    seq_q [2];
    logic           toggle_q;
    logic [31:0]    dgram_q;

    t_hdr header_q [$];   // headers owed by the block, oldest first
    t_hdr seen_hdr;

    int  req_accepted  = 0;
    int  hdr_accepted  = 0;
    int  idle_cycles   = 0;
    int  err_cnt       = 0;
    int  frame_ends    = 0;
    int  pose_headers  = 0;
    int  writes_done   = 0;
    bit  idle_on       = 1'b0;  // sender inserts gaps
    bit  sink_random   = 1'b0;  // receiver stalls at random
    bit  hold_req      = 1'b0;  // receiver should hold off for HOLD_CYCLES

    // Directed table. Cursor trace: 0,1,2,68,136,204,205..208,209,272,340,408,476..748,816.
    t_dir_row directed_tab [DIR_ROWS] = '{
        // after reset: one tile per run, pose at tile 0
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h0000_0000, 1'b1, 12'd0,   7'd1,  1'b1, 16'd31},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'hffff_ffff, 1'b1, 12'd1,   7'd1,  1'b0, 16'd5},
        // run limit above the row width: clipped at end of row
        '{1'b1, trhg_pkg::REG_RUN_LIMIT,   32'd127,       1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h1234_5678, 1'b1, 12'd2,   7'd66, 1'b0, 16'd330},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'ha5a5_a5a5, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        // largest tile size: payload wraps at 16 bits
        '{1'b1, trhg_pkg::REG_TILE_SIZE,   32'd4095,      1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h5a5a_5a5a, 1'b1, 12'd136, 7'd68, 1'b0, 16'd16588},
        // zero run limit and zero tile size both act as one
        '{1'b1, trhg_pkg::REG_RUN_LIMIT,   32'd0,         1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b1, trhg_pkg::REG_TILE_SIZE,   32'd0,         1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h0f0f_0f0f, 1'b1, 12'd204, 7'd1,  1'b0, 16'd5},
        // two paths: ids alternate, each path keeps its own sequence
        '{1'b1, trhg_pkg::REG_TWO_PATHS,   32'd1,         1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'hf0f0_f0f0, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h8000_0000, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h0000_0001, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h7fff_ffff, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        // runs of up to a full row with pose disabled: band start at row 6 has no pose
        '{1'b1, trhg_pkg::REG_RUN_LIMIT,   32'd68,        1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b1, trhg_pkg::REG_POSE_ENABLE, 32'd0,         1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'hdead_beef, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'hcafe_f00d, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h0123_4567, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h89ab_cdef, 1'b1, 12'd408, 7'd68, 1'b0, 16'd340},
        // pose back on: next band start at row 12
        '{1'b1, trhg_pkg::REG_POSE_ENABLE, 32'd1,         1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h1111_1111, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h2222_2222, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h4444_4444, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h8888_8888, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'h5555_5555, 1'b0, 12'd0,   7'd0,  1'b0, 16'd0},
        '{1'b0, trhg_pkg::REG_RUN_LIMIT,   32'haaaa_aaaa, 1'b1, 12'd816, 7'd68, 1'b1, 16'd366}
    };

    tile_run_header_generator_unit #(
        .GRID_COLUMNS  (COLS),
        .GRID_ROWS     (ROWS),
        .ROWS_PER_BAND (ROWS_PER_BAND),
        .BAND_COUNT    (BANDS)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_tx_time            (i_tx_time),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_frame_number       (o_frame_number),
        .o_first_tile         (o_first_tile),
        .o_tile_count         (o_tile_count),
        .o_last_of_frame      (o_last_of_frame),
        .o_band_index         (o_band_index),
        .o_run_class          (o_run_class),
        .o_pose_flag          (o_pose_flag),
        .o_path_id            (o_path_id),
        .o_path_sequence      (o_path_sequence),
        .o_payload_length     (o_payload_length),
        .o_self_test_sequence (o_self_test_sequence),
        .o_stamp_time         (o_stamp_time),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Header for the next request; advances the walker, path and datagram state.
    function automatic t_hdr predict_header(input logic [31:0] tx);
        int unsigned per_run, tbytes, cur, row, col, cnt, band, pay;
        logic        pid;
        t_hdr        h;
        per_run = (cfg_q.run_limit == 0) ? 1 : cfg_q.run_limit;
        tbytes  = (cfg_q.tile_size == 0) ? 1 : cfg_q.tile_size;
        cur     = (cursor_q >= TILE_TOTAL) ? 0 : cursor_q;
        row     = cur / COLS;
        col     = cur % COLS;
        // clip at end of row, then at end of frame
        cnt = (per_run < COLS - col) ? per_run : COLS - col;
        cnt = (cnt < TILE_TOTAL - cur) ? cnt : TILE_TOTAL - cur;
        if (cnt == 0) cnt = 1;
        band = row / ROWS_PER_BAND;
        if (band > BANDS - 1) band = BANDS - 1;

        h.run.frame_number  = frame_q;
        h.run.first_tile    = cur[11:0];
        h.run.tile_count    = cnt[6:0];
        h.run.last_of_frame = (cur + cnt >= TILE_TOTAL);
        h.run.band_index    = band[2:0];
        if (band < 2)
            h.run.run_class = trhg_pkg::CLASS_LOW;
        else if (band < 4)
            h.run.run_class = trhg_pkg::CLASS_MID;
        else
            h.run.run_class = trhg_pkg::CLASS_HIGH;
        h.run.pose_flag     = cfg_q.pose_enable && (col == 0) && (row % ROWS_PER_BAND == 0);

        pay = (h.run.pose_flag ? trhg_pkg::POSE_HDR_LEN : 0)
              + cnt * trhg_pkg::DIR_ENTRY_BYTES + cnt * tbytes;
        h.payload_length = pay[15:0];
        h.stamp_time     = tx;

        // single path leaves the toggle alone
        pid = 1'b0;
        if (cfg_q.two_paths) begin
            pid      = toggle_q;
            toggle_q = ~toggle_q;
        end
        h.path.path_id            = pid;
        h.path.path_sequence      = seq_q[pid];
        seq_q[pid]                = seq_q[pid] + 14'd1;
        h.path.self_test_sequence = dgram_q;
        dgram_q                   = dgram_q + 32'd1;

        cursor_q = cur + cnt;
        if (cursor_q >= TILE_TOTAL) begin
            cursor_q = 0;
            frame_q  = frame_q + 16'd1;
        end
        return h;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Sender gap: mostly back-to-back, some short gaps, a few long ones.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [31:0] random_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 32'h0000_0000;
        if (r < 8) return 32'hffff_ffff;
        return $urandom();
    endfunction

    // Offer one request; called and returning at a falling edge. Valid stays
    // high on return so back-to-back requests need no extra assignment.
    task automatic send_request(input logic [31:0] tx, input int gap, input t_dir_row typed_row);
        int   seen;
        t_hdr h;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        seen = req_accepted;
        i_valid   <= 1'b1;
        i_tx_time <= tx;
        do @(negedge i_clk); while (req_accepted == seen);
        // the header register sits behind the input register, so pushing here is in time
        h = predict_header(tx);
        if (typed_row.typed) begin
            h.run.first_tile    = typed_row.first_tile;
            h.run.tile_count    = typed_row.tile_count;
            h.run.pose_flag     = typed_row.pose_flag;
            h.payload_length    = typed_row.payload_length;
        end
        header_q.push_back(h);
    endtask

    // Stop offering, then wait for every owed header plus the pipeline depth.
    task automatic drain();
        i_valid <= 1'b0;
        while (header_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write followed by a read-back; block must be idle.
    task automatic write_reg(input trhg_pkg::t_reg_idx idx, input logic [31:0] data);
        logic [31:0] field, rd;
        case (idx)
            trhg_pkg::REG_RUN_LIMIT: begin
                field = data & 32'h7f;
                cfg_q.run_limit = field[6:0];
            end
            trhg_pkg::REG_TILE_SIZE: begin
                field = data & 32'hfff;
                cfg_q.tile_size = field[11:0];
            end
            trhg_pkg::REG_TWO_PATHS: begin
                field = data & 32'h1;
                cfg_q.two_paths = field[0];
            end
            default: begin
                field = data & 32'h1;
                cfg_q.pose_enable = field[0];
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        // straight into the read setup phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cmp_field("prdata", field, rd);
        writes_done++;
    endtask

    // Monitor: counts request handshakes, checks each header against the oldest
    // expectation, and tracks cycles without any handshake for the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (i_valid && o_ready) req_accepted <= req_accepted + 1;
            if (o_valid && i_ready) begin
                hdr_accepted <= hdr_accepted + 1;
                if (o_last_of_frame) frame_ends <= frame_ends + 1;
                if (o_pose_flag) pose_headers <= pose_headers + 1;
                if (header_q.size() == 0) begin
                    $error("header with no request outstanding: first_tile 0x%0h", o_first_tile);
                    err_cnt++;
                end else begin
                    seen_hdr = header_q.pop_front();
                    cmp_field("frame_number",       seen_hdr.run.frame_number,    o_frame_number);
                    cmp_field("first_tile",         seen_hdr.run.first_tile,      o_first_tile);
                    cmp_field("tile_count",         seen_hdr.run.tile_count,      o_tile_count);
                    cmp_field("last_of_frame",      seen_hdr.run.last_of_frame,   o_last_of_frame);
                    cmp_field("band_index",         seen_hdr.run.band_index,      o_band_index);
                    cmp_field("run_class",          seen_hdr.run.run_class,       o_run_class);
                    cmp_field("pose_flag",          seen_hdr.run.pose_flag,       o_pose_flag);
                    cmp_field("path_id",            seen_hdr.path.path_id,        o_path_id);
                    cmp_field("path_sequence",      seen_hdr.path.path_sequence,  o_path_sequence);
                    cmp_field("payload_length",     seen_hdr.payload_length,      o_payload_length);
                    cmp_field("self_test_sequence", seen_hdr.path.self_test_sequence,
                              o_self_test_sequence);
                    cmp_field("stamp_time",         seen_hdr.stamp_time,          o_stamp_time);
                end
            end
        end
    end

    // Receiver: always ready, random stalls, or a long counted hold-off on request.
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!sink_random || !i_rst_n) begin
                i_ready <= i_rst_n;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(15, 60);
                end
            end
        end
    end

    // Watchdog: no handshake on either channel for too long ends the run.
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL tile_run_header_generator_unit");
        $finish;
    end

    // Main sequence
    initial begin
        int          row_idx;
        int          phase;
        int          k;
        int          pick;
        logic [6:0]  tpr;
        logic [11:0] tbytes;

        // predictor mirrors the reset state
        cfg_q.run_limit   = 7'd1;
        cfg_q.tile_size   = 12'd1;
        cfg_q.two_paths   = 1'b0;
        cfg_q.pose_enable = 1'b1;
        cursor_q = 0;
        frame_q  = '0;
        seq_q[0] = '0;
        seq_q[1] = '0;
        toggle_q = 1'b0;
        dgram_q  = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, with light idling on both sides.
        idle_on     = 1'b1;
        sink_random = 1'b1;
        for (row_idx = 0; row_idx < DIR_ROWS; row_idx++) begin
            if (directed_tab[row_idx].is_write) begin
                drain();
                write_reg(directed_tab[row_idx].reg_sel, directed_tab[row_idx].value);
            end else begin
                send_request(directed_tab[row_idx].value, random_gap(), directed_tab[row_idx]);
            end
        end

        // Random phases: fresh settings each time, extremes weighted in.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            pick = $urandom_range(0, 9);
            tpr  = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd1 : (pick == 2) ? 7'd68 :
                   (pick == 3) ? 7'd127 : 7'($urandom_range(1, 68));
            pick   = $urandom_range(0, 9);
            tbytes = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd1 : (pick == 2) ? 12'd4095 :
                     12'($urandom_range(1, 4095));
            // upper data bits are noise the register must drop
            write_reg(trhg_pkg::REG_RUN_LIMIT, ($urandom() & ~32'h7f) | tpr);
            write_reg(trhg_pkg::REG_TILE_SIZE, ($urandom() & ~32'hfff) | tbytes);
            write_reg(trhg_pkg::REG_TWO_PATHS, ($urandom() & ~32'h1) | $urandom_range(0, 1));
            write_reg(trhg_pkg::REG_POSE_ENABLE, ($urandom() & ~32'h1) | $urandom_range(0, 1));

            // every third phase runs at full rate on both sides
            idle_on     = (phase % 3 != 0);
            sink_random = (phase % 3 != 0);
            if (phase == PRESSURE_PHASE) begin
                // receiver holds off while the sender keeps offering; input must stall
                idle_on  = 1'b0;
                hold_req = 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS; k++)
                send_request(random_stamp(), random_gap(), PLAIN_REQUEST);
        end

        drain();

        $display("Run covered %0d requests, %0d headers, %0d frame ends, %0d pose headers.",
                 req_accepted, hdr_accepted, frame_ends, pose_headers);
        $display("%0d register writes, %0d random settings, one long receiver hold-off.",
                 writes_done, RANDOM_PHASES);
        if (err_cnt == 0) begin
            $display("PASS tile_run_header_generator_unit");
        end else begin
            $display("FAIL tile_run_header_generator_unit");
        end
        $finish;
    end

endmodule
